/* rtl/core/gbc_pkg.sv */
// Shared types, S-box table and round function for the GOST block cipher.
package gbc_pkg;

    localparam int ROUNDS    = 32;
    localparam int KEY_WORDS = 8;
    localparam int CFG_IDX_W = 4;
    localparam int ROT       = 11;

    typedef logic [31:0] t_word;
    typedef logic [KEY_WORDS-1:0][31:0] t_key_array;

    typedef struct packed {
        logic  mode;
        t_word a;
        t_word b;
    } t_stage;

    localparam logic [7:0] SBOX_ROWS [64] = '{
        8'hC7, 8'hE0, 8'h0A, 8'h25, 8'hF2, 8'hD4, 8'h4B, 8'h73,
        8'h68, 8'h9E, 8'h89, 8'h3C, 8'h11, 8'h56, 8'hAF, 8'hBD,
        8'hA9, 8'hEA, 8'h14, 8'h07, 8'h41, 8'hC5, 8'h56, 8'h7D,
        8'h20, 8'h82, 8'h6F, 8'h9E, 8'hB3, 8'hFC, 8'hD8, 8'h3B,
        8'h2A, 8'h43, 8'h0F, 8'hFE, 8'h90, 8'hE6, 8'h85, 8'h68,
        8'hA1, 8'h1C, 8'h3D, 8'hDB, 8'hC7, 8'h79, 8'hB2, 8'h54,
        8'h10, 8'h78, 8'h5D, 8'h45, 8'hF3, 8'h3E, 8'h07, 8'h29,
        8'hEF, 8'h8B, 8'hDC, 8'h64, 8'hCA, 8'hB1, 8'hA6, 8'h92
    };

    function automatic t_word substitute(input t_word x);
        t_word      r;
        logic [7:0] lo_e;
        logic [7:0] hi_e;
        r = '0;
        for (int j = 0; j < 4; j++) begin
            lo_e = SBOX_ROWS[{j[1:0], x[8*j +: 4]}];
            hi_e = SBOX_ROWS[{j[1:0], x[8*j+4 +: 4]}];
            r[8*j +: 8] = {hi_e[7:4], lo_e[3:0]};
        end
        return r;
    endfunction

    function automatic t_word round_fn(input t_word half, input t_word k);
        t_word s;
        s = substitute(half + k);
        return {s[31-ROT:0], s[31:32-ROT]};
    endfunction

endpackage

/* rtl/core/gbc_key_file.sv */
// Key word registers written through the configuration channel.
module gbc_key_file import gbc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output t_key_array           o_keys
);

    t_key_array r_keys;

    assign o_cfg_ready = 1'b1;
    assign o_keys      = r_keys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else if (i_cfg_valid && i_cfg_index < CFG_IDX_W'(KEY_WORDS)) begin
            r_keys[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

endmodule

/* rtl/core/gbc_round_cell.sv */
// One Feistel round cell of the cipher pipeline.
module gbc_round_cell import gbc_pkg::*; #(
    parameter int ROUND = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_stage     i_stage,
    input  t_key_array i_keys,
    output logic       o_valid,
    output t_stage     o_stage
);

    localparam int POS     = ROUND % 8;
    localparam int KEY_ENC = (ROUND < 24) ? POS : 7 - POS;
    localparam int KEY_DEC = (ROUND < 8)  ? POS : 7 - POS;

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;
    t_word  key;

    assign key = i_stage.mode ? i_keys[KEY_DEC] : i_keys[KEY_ENC];

    always_comb begin
        n_stage.mode = i_stage.mode;
        n_stage.a    = round_fn(i_stage.a, key) ^ i_stage.b;
        n_stage.b    = i_stage.a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

/* rtl/core/gost_block_cipher_ecb.sv */
// Top level: GOST 28147-89 ECB block cipher, 32-cell round pipeline.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  input     | start & !busy             | i_mode, i_word_low, i_word_high
//  result    | o_valid (one cycle)       | o_out_low, o_out_high
//  config    | i_cfg_valid & o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One item enters per cycle; each passes through the registered round cells
//  of the 32-cell chain in order, and its result leaves the last cell.
//  busy stays low: the chain never stalls and results cannot be held off.
//  Synchronous active-low reset clears the keys and the cell valid bits.
module gost_block_cipher_ecb import gbc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_mode,
    input  logic [31:0]          i_word_low,
    input  logic [31:0]          i_word_high,
    output logic                 o_valid,
    output logic [31:0]          o_out_low,
    output logic [31:0]          o_out_high,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_key_array keys;
    logic       valid_chain [ROUNDS+1];
    t_stage     stage_chain [ROUNDS+1];

    assign busy = 1'b0;

    gbc_key_file u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_keys      (keys)
    );

    assign valid_chain[0]      = start && !busy;
    assign stage_chain[0].mode = i_mode;
    assign stage_chain[0].a    = i_word_low;
    assign stage_chain[0].b    = i_word_high;

    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        gbc_round_cell #(.ROUND(r)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid_chain[r]),
            .i_stage (stage_chain[r]),
            .i_keys  (keys),
            .o_valid (valid_chain[r+1]),
            .o_stage (stage_chain[r+1])
        );
    end

    assign o_valid    = valid_chain[ROUNDS];
    assign o_out_low  = stage_chain[ROUNDS].b;
    assign o_out_high = stage_chain[ROUNDS].a;

endmodule
